/* hdl/dfmt_pkg.sv */
package dfmt_pkg;

   localparam int GuestBits   = 32;
   localparam int FrameBits   = 16;
   localparam int SampleBits  = 20;
   localparam int BufferBits  = 16;
   localparam int BaseBits    = 48;
   localparam int IdxBits     = 2;
   localparam int DivBits     = 64;

   localparam int PhaseBitsDefault = 20;
   localparam int CycleBitsDefault = 64;

   localparam logic [GuestBits-1:0]  GuestReset  = 32'd200000000;
   localparam logic [FrameBits-1:0]  FrameReset  = 16'd60;
   localparam logic [SampleBits-1:0] SampleReset = 20'd44100;
   localparam logic [BufferBits-1:0] BufferReset = 16'd512;

   localparam logic [IdxBits-1:0] RegGuest  = 2'd0;
   localparam logic [IdxBits-1:0] RegFrame  = 2'd1;
   localparam logic [IdxBits-1:0] RegSample = 2'd2;
   localparam logic [IdxBits-1:0] RegBuffer = 2'd3;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_RESET = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO     = 2'd1,
      ST_SUBCYCLE = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // latch request and result-less defaults
      logic       tick;        // serve a tick item
      logic       stop;
      logic       clear;       // reset counters and stop
      logic       div_start;   // launch one division
      logic [1:0] div_sel;     // which division
      logic       vid_build;   // store video cadence from divider
      logic       aud_build;   // store audio cadence
      logic       sched;       // schedule first deadlines
      logic       fail;        // set status and stay stopped
      status_type fail_code;
      logic       finish;      // present result
   } dfmt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       running;
      logic       div_done;
      logic       zero_video;
      logic       zero_audio;
      logic       vbase_zero;
      logic       abase_zero;
   } dfmt_stat_type;

   localparam logic [1:0] DivVidWhole = 2'd0;
   localparam logic [1:0] DivVidFrac  = 2'd1;
   localparam logic [1:0] DivAudWhole = 2'd2;
   localparam logic [1:0] DivAudFrac  = 2'd3;

endpackage

/* hdl/dfmt_if.sv */
interface dfmt_req_if #(parameter int CycleBits = 64);
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [CycleBits-1:0] cycle_count;
   modport source (output valid, req_type, cycle_count, input ready);
   modport sink   (input valid, req_type, cycle_count, output ready);
endinterface

interface dfmt_rsp_if #(parameter int CycleBits = 64);
   logic                 valid;
   logic                 ready;
   logic                 video_fired;
   logic [63:0]          video_index;
   logic                 audio_fired;
   logic [63:0]          audio_index;
   logic [63:0]          audio_first_frame;
   logic [CycleBits-1:0] event_cycle;
   logic                 is_running;
   logic [CycleBits-1:0] next_video_deadline;
   logic [CycleBits-1:0] next_audio_deadline;
   logic [1:0]           status;
   modport source (output valid, video_fired, video_index, audio_fired, audio_index,
                   audio_first_frame, event_cycle, is_running, next_video_deadline,
                   next_audio_deadline, status, input ready);
   modport sink   (input valid, video_fired, video_index, audio_fired, audio_index,
                   audio_first_frame, event_cycle, is_running, next_video_deadline,
                   next_audio_deadline, status, output ready);
endinterface

interface dfmt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dfmt_div.sv */
// Restoring divider, one quotient bit per cycle.
module dfmt_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [dfmt_pkg::DivBits-1:0] dividend,
   input  logic [dfmt_pkg::SampleBits-1:0] divisor,
   output logic                    done,
   output logic [dfmt_pkg::DivBits-1:0] quotient,
   output logic [dfmt_pkg::SampleBits-1:0] remainder
);
   import dfmt_pkg::*;

   localparam int CntBits = $clog2(DivBits + 1);

   logic [DivBits-1:0]    quo_ff, quo_in;
   logic [SampleBits:0]   rem_ff, rem_in;
   logic [SampleBits-1:0] den_ff;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [SampleBits:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SampleBits-1:0], quo_ff[DivBits-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CntBits'(DivBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) den_ff <= divisor;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[SampleBits-1:0];
endmodule

/* hdl/dfmt_ctrl.sv */
// Request sequencer: one transaction at a time, a start runs up to four divisions.
module dfmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_code,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output dfmt_pkg::dfmt_cmd_type  cmd,
   input  dfmt_pkg::dfmt_stat_type stat
);
   import dfmt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_VW, S_VF, S_VB, S_AW, S_AF, S_AB, S_SCHED, S_OUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.fail_code = ST_OK;
      cmd.capture = accept;
      if (accept) begin
         unique case (req_code_type'(req_code))
            REQ_TICK:  cmd.tick  = 1'b1;
            REQ_STOP:  cmd.stop  = 1'b1;
            REQ_RESET: cmd.clear = 1'b1;
            REQ_START: ;
            default: ;
         endcase
      end
      unique case (state_ff)
         S_CHECK: begin
            if (stat.zero_video) begin
               cmd.fail = 1'b1;
               cmd.fail_code = ST_ZERO;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel = DivVidWhole;
            end
         end
         S_VW: if (stat.div_done) begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DivVidFrac;
         end
         S_VF: if (stat.div_done) cmd.vid_build = 1'b1;
         S_VB: begin
            // video cadence settled before the audio rates are looked at
            if (stat.vbase_zero) begin
               cmd.fail = 1'b1;
               cmd.fail_code = ST_SUBCYCLE;
            end else if (stat.zero_audio) begin
               cmd.fail = 1'b1;
               cmd.fail_code = ST_ZERO;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel = DivAudWhole;
            end
         end
         S_AW: if (stat.div_done) begin
            cmd.div_start = 1'b1;
            cmd.div_sel = DivAudFrac;
         end
         S_AF: if (stat.div_done) cmd.aud_build = 1'b1;
         S_AB: begin
            if (stat.abase_zero) begin
               cmd.fail = 1'b1;
               cmd.fail_code = ST_SUBCYCLE;
            end
         end
         S_SCHED: cmd.sched = 1'b1;
         S_IDLE, S_OUT: ;
         default: ;
      endcase
      cmd.finish = (state_ff == S_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_code_type'(req_code) == REQ_START && !stat.running) begin
                     state_ff <= S_CHECK;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_CHECK: state_ff <= stat.zero_video ? S_OUT : S_VW;
            S_VW:    if (stat.div_done) state_ff <= S_VF;
            S_VF:    if (stat.div_done) state_ff <= S_VB;
            S_VB:    state_ff <= (stat.vbase_zero || stat.zero_audio) ? S_OUT : S_AW;
            S_AW:    if (stat.div_done) state_ff <= S_AF;
            S_AF:    if (stat.div_done) state_ff <= S_AB;
            S_AB:    state_ff <= stat.abase_zero ? S_OUT : S_SCHED;
            S_SCHED: state_ff <= S_OUT;
            S_OUT: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/dfmt_dp.sv */
// Cadence store, phase accumulators, deadlines and counters.
module dfmt_dp #(
   parameter int PhaseBits = dfmt_pkg::PhaseBitsDefault,
   parameter int CycleBits = dfmt_pkg::CycleBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dfmt_pkg::dfmt_cmd_type          cmd,
   output dfmt_pkg::dfmt_stat_type         stat,
   input  logic                            csr_we,
   input  logic [dfmt_pkg::IdxBits-1:0]    csr_idx,
   input  logic [31:0]                     csr_wdata,
   input  logic [CycleBits-1:0]            now,
   output logic                            o_video_fired,
   output logic [63:0]                     o_video_index,
   output logic                            o_audio_fired,
   output logic [63:0]                     o_audio_index,
   output logic [63:0]                     o_audio_first_frame,
   output logic [CycleBits-1:0]            o_event_cycle,
   output logic                            o_is_running,
   output logic [CycleBits-1:0]            o_next_video_deadline,
   output logic [CycleBits-1:0]            o_next_audio_deadline,
   output logic [1:0]                      o_status
);
   import dfmt_pkg::*;

   localparam logic [CycleBits-1:0] CycleMax = '1;

   logic [GuestBits-1:0]  guest_ff;
   logic [FrameBits-1:0]  frame_ff;
   logic [SampleBits-1:0] sample_ff;
   logic [BufferBits-1:0] buffer_ff, lbuf_ff;

   logic                  run_ff;
   logic [BaseBits-1:0]   vbase_ff, abase_ff;
   logic [PhaseBits-1:0]  vrem_ff, arem_ff, vph_ff, aph_ff;
   logic [SampleBits-1:0] vden_ff, aden_ff;
   logic [CycleBits-1:0]  vdl_ff, adl_ff, now_ff;
   logic [63:0]           vtot_ff, atot_ff, ftot_ff;
   logic [63:0]           whole_ff;

   logic                  vf_ff, af_ff;
   logic [63:0]           vi_ff, ai_ff, afirst_ff;
   logic [CycleBits-1:0]  ecyc_ff;
   logic [1:0]            status_ff;

   // divider
   logic                  div_done;
   logic [DivBits-1:0]    div_dividend, div_q;
   logic [SampleBits-1:0] div_divisor, div_r;
   logic [35:0]           fprod_in;
   logic [47:0]           wprod;

   // remainder of the whole division, scaled by the buffer size
   assign fprod_in = 36'(div_r) * 36'(buffer_ff);
   assign wprod    = 48'(div_q[31:0]) * 48'(buffer_ff);

   always_comb begin
      unique case (cmd.div_sel)
         DivVidWhole: begin
            div_dividend = DivBits'(guest_ff);
            div_divisor  = SampleBits'(frame_ff);
         end
         DivVidFrac: begin
            div_dividend = DivBits'(div_r);
            div_divisor  = SampleBits'(frame_ff);
         end
         DivAudWhole: begin
            div_dividend = DivBits'(guest_ff);
            div_divisor  = sample_ff;
         end
         default: begin
            div_dividend = DivBits'(fprod_in);
            div_divisor  = sample_ff;
         end
      endcase
   end

   dfmt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Whole step: fprod = remainder * per_tick; whole*per_tick kept for later.
   logic [BaseBits-1:0] cand_base;
   assign cand_base = BaseBits'(whole_ff) + BaseBits'(div_q);

   // Advance helper: new phase and interval.
   function automatic logic [PhaseBits+BaseBits:0] adv(
      input logic [BaseBits-1:0]   base,
      input logic [PhaseBits-1:0]  rem,
      input logic [PhaseBits-1:0]  ph,
      input logic [SampleBits-1:0] den
   );
      logic [PhaseBits-1:0] thr, nph;
      logic [BaseBits:0]    ivl;
      thr = PhaseBits'(den) - rem;
      nph = ph;
      ivl = {1'b0, base};
      if (rem != '0) begin
         if (ph >= thr) begin
            nph = ph - thr;
            ivl = ivl + 1'b1;
         end else begin
            nph = ph + rem;
         end
      end
      return {nph, ivl};
   endfunction

   logic [PhaseBits-1:0] vnph, anph;
   logic [BaseBits:0]    vivl, aivl;
   logic [PhaseBits-1:0] vph_use, aph_use;
   logic [CycleBits-1:0] vdl_use, adl_use;
   logic                 vov, aov, vhit, ahit, fov;

   assign vph_use = cmd.sched ? '0 : vph_ff;
   assign aph_use = cmd.sched ? '0 : aph_ff;
   assign vdl_use = cmd.sched ? now_ff : vdl_ff;
   assign adl_use = cmd.sched ? now_ff : adl_ff;
   assign {vnph, vivl} = adv(vbase_ff, vrem_ff, vph_use, vden_ff);
   assign {anph, aivl} = adv(abase_ff, arem_ff, aph_use, aden_ff);

   always_comb begin
      if (CycleBits > BaseBits + 1)
         vov = CycleBits'(vivl) > (CycleMax - vdl_use);
      else
         vov = vivl > (BaseBits+1)'(CycleMax - vdl_use);
      if (CycleBits > BaseBits + 1)
         aov = CycleBits'(aivl) > (CycleMax - adl_use);
      else
         aov = aivl > (BaseBits+1)'(CycleMax - adl_use);
   end

   assign vhit = run_ff && (now >= vdl_ff);
   assign ahit = now >= adl_ff;
   assign fov  = {48'd0, lbuf_ff} > (64'hFFFF_FFFF_FFFF_FFFF - ftot_ff);

   assign stat.running    = run_ff;
   assign stat.div_done   = div_done;
   assign stat.zero_video = (guest_ff == '0) || (frame_ff == '0);
   assign stat.zero_audio = (sample_ff == '0) || (buffer_ff == '0);
   assign stat.vbase_zero = (vbase_ff == '0);
   assign stat.abase_zero = (abase_ff == '0);

   always_ff @(posedge clock) begin
      logic                 run_v, vserve_ok, vf_v, af_v;
      logic [63:0]          vi_v, ai_v, afirst_v;
      logic [CycleBits-1:0] ecyc_v;
      logic [1:0]           status_v;
      run_v     = run_ff;
      vserve_ok = 1'b1;
      vf_v      = vf_ff;
      af_v      = af_ff;
      vi_v      = vi_ff;
      ai_v      = ai_ff;
      afirst_v  = afirst_ff;
      ecyc_v    = ecyc_ff;
      status_v  = status_ff;
      if (reset) begin
         guest_ff  <= GuestReset;
         frame_ff  <= FrameReset;
         sample_ff <= SampleReset;
         buffer_ff <= BufferReset;
         run_ff    <= 1'b0;
         vbase_ff  <= '0; abase_ff <= '0;
         vrem_ff   <= '0; arem_ff  <= '0;
         vph_ff    <= '0; aph_ff   <= '0;
         vden_ff   <= '0; aden_ff  <= '0;
         vdl_ff    <= '0; adl_ff   <= '0;
         vtot_ff   <= '0; atot_ff  <= '0; ftot_ff <= '0;
         lbuf_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               RegGuest:  guest_ff  <= csr_wdata;
               RegFrame:  frame_ff  <= csr_wdata[FrameBits-1:0];
               RegSample: sample_ff <= csr_wdata[SampleBits-1:0];
               RegBuffer: buffer_ff <= csr_wdata[BufferBits-1:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            now_ff   <= now;
            status_v = ST_OK;
            vf_v     = 1'b0;
            af_v     = 1'b0;
            vi_v     = '0;
            ai_v     = '0;
            afirst_v = '0;
            ecyc_v   = '0;
         end
         if (cmd.stop) run_ff <= 1'b0;
         if (cmd.clear) begin
            run_ff <= 1'b0;
            vtot_ff <= '0; atot_ff <= '0; ftot_ff <= '0;
            vph_ff <= '0; aph_ff <= '0;
            vdl_ff <= now; adl_ff <= now;
         end
         if (cmd.tick && run_ff) begin
            if (vhit) begin
               vf_v    = 1'b1;
               vi_v    = vtot_ff;
               ecyc_v  = now;
               vtot_ff <= vtot_ff + 1'b1;
               vph_ff  <= vnph;
               if (vov) begin
                  status_v  = ST_OVERFLOW;
                  run_v     = 1'b0;
                  vserve_ok = 1'b0;
               end else begin
                  vdl_ff <= vdl_ff + CycleBits'(vivl);
               end
            end
            if (vserve_ok && ahit) begin
               if (fov) begin
                  status_v = ST_OVERFLOW;
                  run_v    = 1'b0;
               end else begin
                  af_v     = 1'b1;
                  ai_v     = atot_ff;
                  afirst_v = ftot_ff;
                  ecyc_v   = now;
                  atot_ff <= atot_ff + 1'b1;
                  ftot_ff <= ftot_ff + 64'(lbuf_ff);
                  aph_ff <= anph;
                  if (aov) begin
                     status_v = ST_OVERFLOW;
                     run_v    = 1'b0;
                  end else begin
                     adl_ff <= adl_ff + CycleBits'(aivl);
                  end
               end
            end
            run_ff <= run_v;
         end
         // start sequence
         if (cmd.div_start && (cmd.div_sel == DivVidWhole || cmd.div_sel == DivAudWhole)) begin
            whole_ff <= '0;
         end
         if (div_done && cmd.div_start) begin
            // whole division finished: keep whole*per_tick
            if (cmd.div_sel == DivVidFrac) begin
               whole_ff <= div_q;
            end else begin
               whole_ff <= 64'(wprod);
            end
         end
         if (cmd.vid_build) begin
            vbase_ff <= cand_base;
            vrem_ff  <= PhaseBits'(div_r);
            vden_ff  <= SampleBits'(frame_ff);
         end
         if (cmd.aud_build) begin
            abase_ff <= cand_base;
            arem_ff  <= PhaseBits'(div_r);
            aden_ff  <= sample_ff;
            lbuf_ff  <= buffer_ff;
         end
         if (cmd.fail) status_v = cmd.fail_code;
         if (cmd.sched) begin
            vph_ff <= vnph;
            aph_ff <= anph;
            vdl_ff <= now_ff + CycleBits'(vivl);
            adl_ff <= now_ff + CycleBits'(aivl);
            if (vov || aov) begin
               status_v = ST_OVERFLOW;
            end else begin
               run_ff <= 1'b1;
            end
         end
         vf_ff     <= vf_v;
         af_ff     <= af_v;
         vi_ff     <= vi_v;
         ai_ff     <= ai_v;
         afirst_ff <= afirst_v;
         ecyc_ff   <= ecyc_v;
         status_ff <= status_v;
      end
   end

   assign o_video_fired         = vf_ff;
   assign o_video_index         = vi_ff;
   assign o_audio_fired         = af_ff;
   assign o_audio_index         = ai_ff;
   assign o_audio_first_frame   = afirst_ff;
   assign o_event_cycle         = ecyc_ff;
   assign o_is_running          = run_ff;
   assign o_next_video_deadline = run_ff ? vdl_ff : '0;
   assign o_next_audio_deadline = run_ff ? adl_ff : '0;
   assign o_status              = status_ff;
endmodule

/* hdl/dual_fractional_media_tick_generator.sv */
// Tick, stop and reset transactions pass from acceptance through the output state to the registered result.
// A start transaction from stopped runs up to four divisions before its result.
// One transaction at a time, taken only while idle; the shared divider sets start cost.
// Reset is synchronous, active high: configuration registers return to their default values, block stopped.
module dual_fractional_media_tick_generator #(
   parameter int PhaseBits = dfmt_pkg::PhaseBitsDefault,
   parameter int CycleBits = dfmt_pkg::CycleBitsDefault
) (
   input logic clock,
   input logic reset,
   dfmt_req_if.sink   req,
   dfmt_rsp_if.source rsp,
   dfmt_csr_if.sink   csr
);
   import dfmt_pkg::*;

   dfmt_cmd_type  cmd;
   dfmt_stat_type stat;

   // configuration always taken; the user must write it only while idle, the block does not enforce this
   assign csr.ready = 1'b1;

   dfmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_code  (req.req_type),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: cadences, phase accumulators, deadlines, totals
   dfmt_dp #(.PhaseBits(PhaseBits), .CycleBits(CycleBits)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_we                (csr.valid),
      .csr_idx               (csr.index),
      .csr_wdata             (csr.data),
      .now                   (req.cycle_count),
      .o_video_fired         (rsp.video_fired),
      .o_video_index         (rsp.video_index),
      .o_audio_fired         (rsp.audio_fired),
      .o_audio_index         (rsp.audio_index),
      .o_audio_first_frame   (rsp.audio_first_frame),
      .o_event_cycle         (rsp.event_cycle),
      .o_is_running          (rsp.is_running),
      .o_next_video_deadline (rsp.next_video_deadline),
      .o_next_audio_deadline (rsp.next_audio_deadline),
      .o_status              (rsp.status)
   );
endmodule

/* hdl/dfmt_checker.sv */
module dfmt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_running,
   input logic [1:0] rsp_status,
   input logic       rsp_video_fired,
   input logic       rsp_audio_fired
);
   import dfmt_pkg::*;

   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_is_running)
      else $error("error status while running");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_video_fired && rsp_audio_fired |-> rsp_status != ST_SUBCYCLE)
      else $error("tick with cadence error");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
endmodule

bind dual_fractional_media_tick_generator dfmt_checker u_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_is_running  (rsp.is_running),
   .rsp_status      (rsp.status),
   .rsp_video_fired (rsp.video_fired),
   .rsp_audio_fired (rsp.audio_fired)
);

/* dv/dual_fractional_media_tick_generator_tb.sv */
module dual_fractional_media_tick_generator_tb;
   import dfmt_pkg::*;

   typedef struct packed {
      logic        video_fired;
      logic [63:0] video_index;
      logic        audio_fired;
      logic [63:0] audio_index;
      logic [63:0] audio_first_frame;
      logic [63:0] event_cycle;
      logic        is_running;
      logic [63:0] next_video_deadline;
      logic [63:0] next_audio_deadline;
      status_type  status;
   } tick_result_type;

   // Tick scheduler mirror plus the queue of results it owes.
   // Stream 0 is video, stream 1 is audio.
   class tick_scoreboard;
      localparam logic [63:0] PhaseMask = 64'hF_FFFF;
      localparam logic [63:0] BaseMask  = 64'hFFFF_FFFF_FFFF;

      logic [63:0] guest_rate, video_rate, sample_rate, frames_per_buffer;
      bit          running;
      logic [63:0] base[2], rem[2], phase[2], deadline[2], den[2];
      logic [63:0] latched_buffer, video_total, audio_total, frames_total;
      tick_result_type owed[$];
      int          errors;

      function new();
         guest_rate = GuestReset;
         video_rate = FrameReset;
         sample_rate = SampleReset;
         frames_per_buffer = BufferReset;
         running = 0;
         for (int s = 0; s < 2; s++) begin
            base[s] = 0; rem[s] = 0; phase[s] = 0; deadline[s] = 0; den[s] = 0;
         end
         latched_buffer = 0;
         video_total = 0;
         audio_total = 0;
         frames_total = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         case (idx)
            RegGuest:  guest_rate = data;
            RegFrame:  video_rate = data[15:0];
            RegSample: sample_rate = data[19:0];
            RegBuffer: frames_per_buffer = data[15:0];
            default: ;
         endcase
      endfunction

      // Whole interval plus remainder of cps * per_tick / per_sec.
      function status_type build_cadence(int s, logic [63:0] cps, logic [63:0] per_tick,
                                         logic [63:0] per_sec);
         logic [63:0] whole, frac, fprod, b;
         if (cps == 0 || per_tick == 0 || per_sec == 0) return ST_ZERO;
         whole = cps / per_sec;
         frac  = cps % per_sec;
         fprod = frac * per_tick;
         b     = whole * per_tick + fprod / per_sec;
         if (b == 0) return ST_SUBCYCLE;
         base[s] = b & BaseMask;
         rem[s]  = (fprod % per_sec) & PhaseMask;
         den[s]  = per_sec;
         return ST_OK;
      endfunction

      // Push a deadline on by one interval; 0 if it would wrap.
      function bit advance(int s);
         logic [63:0] interval, thr;
         interval = base[s];
         if (rem[s] != 0) begin
            thr = (den[s] - rem[s]) & PhaseMask;
            if (phase[s] >= thr) begin
               phase[s] = (phase[s] - thr) & PhaseMask;
               interval += 1;
            end else begin
               phase[s] = (phase[s] + rem[s]) & PhaseMask;
            end
         end
         if (interval > ~deadline[s]) return 0;
         deadline[s] += interval;
         return 1;
      endfunction

      function void note_request(req_code_type kind, logic [63:0] now);
         tick_result_type r;
         r = '0;
         r.status = ST_OK;
         case (kind)
            REQ_START: if (!running) begin
               r.status = build_cadence(0, guest_rate, 1, video_rate);
               if (r.status == ST_OK)
                  r.status = build_cadence(1, guest_rate, frames_per_buffer, sample_rate);
               if (r.status == ST_OK) begin
                  latched_buffer = frames_per_buffer;
                  phase[0] = 0; phase[1] = 0;
                  deadline[0] = now; deadline[1] = now;
                  running = 1;
                  if (!advance(0) || !advance(1)) begin
                     r.status = ST_OVERFLOW;
                     running = 0;
                  end
               end
            end
            REQ_STOP: running = 0;
            REQ_RESET: begin
               running = 0;
               video_total = 0; audio_total = 0; frames_total = 0;
               phase[0] = 0; phase[1] = 0;
               deadline[0] = now; deadline[1] = now;
            end
            default: if (running) begin
               if (now >= deadline[0]) begin
                  r.video_fired = 1;
                  r.video_index = video_total;
                  r.event_cycle = now;
                  video_total += 1;
                  if (!advance(0)) begin
                     r.status = ST_OVERFLOW;
                     running = 0;
                  end
               end
               // a video overflow leaves audio unserved
               if (running && now >= deadline[1]) begin
                  if (latched_buffer > ~frames_total) begin
                     r.status = ST_OVERFLOW;
                     running = 0;
                  end else begin
                     r.audio_fired = 1;
                     r.audio_index = audio_total;
                     r.audio_first_frame = frames_total;
                     r.event_cycle = now;
                     audio_total += 1;
                     frames_total += latched_buffer;
                     if (!advance(1)) begin
                        r.status = ST_OVERFLOW;
                        running = 0;
                     end
                  end
               end
            end
         endcase
         r.is_running = running;
         r.next_video_deadline = running ? deadline[0] : '0;
         r.next_audio_deadline = running ? deadline[1] : '0;
         owed.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check_result(tick_result_type got);
         tick_result_type want;
         if (owed.size() == 0) begin
            report("unexpected result transaction", '0, '0);
            return;
         end
         want = owed.pop_front();
         if (got.video_fired !== want.video_fired)
            report("video_fired", got.video_fired, want.video_fired);
         if (got.video_index !== want.video_index)
            report("video_index", got.video_index, want.video_index);
         if (got.audio_fired !== want.audio_fired)
            report("audio_fired", got.audio_fired, want.audio_fired);
         if (got.audio_index !== want.audio_index)
            report("audio_index", got.audio_index, want.audio_index);
         if (got.audio_first_frame !== want.audio_first_frame)
            report("audio_first_frame", got.audio_first_frame, want.audio_first_frame);
         if (got.event_cycle !== want.event_cycle)
            report("event_cycle", got.event_cycle, want.event_cycle);
         if (got.is_running !== want.is_running)
            report("is_running", got.is_running, want.is_running);
         if (got.next_video_deadline !== want.next_video_deadline)
            report("next_video_deadline", got.next_video_deadline, want.next_video_deadline);
         if (got.next_audio_deadline !== want.next_audio_deadline)
            report("next_audio_deadline", got.next_audio_deadline, want.next_audio_deadline);
         if (got.status !== want.status)
            report("status", got.status, want.status);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   calm = 0;       // set to suppress all idling on both sides
   tick_scoreboard sb = new();

   dfmt_req_if #(.CycleBits(64)) req_bus();
   dfmt_rsp_if #(.CycleBits(64)) rsp_bus();
   dfmt_csr_if                   csr_bus();

   dual_fractional_media_tick_generator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #20000000;
      $display("[dual_fractional_media_tick_generator] ERROR");
      $finish;
   end

   // Response side back-pressure, applied at the falling edge.
   always @(negedge clock) rsp_bus.ready <= calm || ($urandom_range(99) >= 18);

   // Monitor: every handshake is sampled at the rising edge.
   always @(posedge clock) if (!reset) begin
      if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.index, csr_bus.data);
      if (req_bus.valid && req_bus.ready)
         sb.note_request(req_code_type'(req_bus.req_type), req_bus.cycle_count);
      if (rsp_bus.valid && rsp_bus.ready) begin
         tick_result_type got;
         got.video_fired         = rsp_bus.video_fired;
         got.video_index         = rsp_bus.video_index;
         got.audio_fired         = rsp_bus.audio_fired;
         got.audio_index         = rsp_bus.audio_index;
         got.audio_first_frame   = rsp_bus.audio_first_frame;
         got.event_cycle         = rsp_bus.event_cycle;
         got.is_running          = rsp_bus.is_running;
         got.next_video_deadline = rsp_bus.next_video_deadline;
         got.next_audio_deadline = rsp_bus.next_audio_deadline;
         got.status              = status_type'(rsp_bus.status);
         sb.check_result(got);
      end
   end

   // Drive one request transaction; called and returning at a falling edge.
   task automatic send_request(req_code_type kind, logic [63:0] cyc);
      while (!calm && $urandom_range(99) < 18) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.req_type = kind;
      req_bus.cycle_count = cyc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      req_bus.valid = 0;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_bus.valid = 1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 0;
   endtask

   // Registers only change with nothing in flight.
   task automatic drain();
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic configure(logic [31:0] cps, logic [15:0] fr, logic [19:0] sr,
                            logic [15:0] bufsz);
      drain();
      write_reg(RegGuest, cps);
      write_reg(RegFrame, {16'd0, fr});
      write_reg(RegSample, {12'd0, sr});
      write_reg(RegBuffer, {16'd0, bufsz});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly well-formed runs: reset, start, then ticks advancing by up to twice
   // the shorter cadence, with stops, restarts and stray transactions mixed in.
   task automatic run_session(int n, logic [63:0] now);
      logic [63:0] span, step;
      int pick;
      send_request(REQ_RESET, now);
      send_request(REQ_START, now);
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            span = sb.running ? ((sb.base[0] < sb.base[1]) ? sb.base[0] : sb.base[1]) : 64'd50;
            step = rand64() % (2 * span + 1);
            now += step;
            send_request(REQ_TICK, now);
         end else if (pick < 85) begin
            send_request(REQ_STOP, now);
         end else if (pick < 88) begin
            send_request(REQ_RESET, now);
         end else if (pick < 95) begin
            send_request(REQ_START, now);
         end else begin
            send_request(req_code_type'($urandom_range(3)), rand64());
         end
      end
   endtask

   initial begin
      logic [63:0] top;
      req_bus.valid = 0;
      req_bus.req_type = REQ_TICK;
      req_bus.cycle_count = '0;
      csr_bus.valid = 0;
      csr_bus.index = RegGuest;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reset settings, first deadlines, start while running, early,
      // exact and late ticks, tick while stopped.
      send_request(REQ_TICK, 64'd5);
      send_request(REQ_START, 64'd1000);
      send_request(REQ_START, 64'd2000);
      send_request(REQ_TICK, 64'd1001);
      send_request(REQ_TICK, sb.deadline[0]);
      send_request(REQ_TICK, sb.deadline[1]);
      send_request(REQ_TICK, 64'd50_000_000);
      send_request(REQ_TICK, 64'd50_000_000);
      send_request(REQ_STOP, 64'd50_000_001);
      send_request(REQ_TICK, 64'd60_000_000);
      send_request(REQ_RESET, 64'd70_000_000);
      send_request(REQ_START, 64'hFFFF_FFFF_FFFF_FFF0);   // overflow at start
      send_request(REQ_TICK, 64'hFFFF_FFFF_FFFF_FFFF);

      // Zero rate on every register, video checked before audio.
      configure(32'd0, 16'd60, 20'd44100, 16'd512);
      send_request(REQ_START, 64'd1);
      configure(32'd1000, 16'd0, 20'd0, 16'd512);
      send_request(REQ_START, 64'd1);
      configure(32'd1000, 16'd60, 20'd0, 16'd512);
      send_request(REQ_START, 64'd1);
      configure(32'd1000, 16'd60, 20'd44100, 16'd0);
      send_request(REQ_START, 64'd1);
      // Sub-cycle cadences, video then audio.
      configure(32'd10, 16'd60, 20'd44100, 16'd512);
      send_request(REQ_START, 64'd1);
      configure(32'd1000, 16'd60, 20'd1_048_575, 16'd1);
      send_request(REQ_START, 64'd1);

      // Short cadences near the top of the cycle range: deadline overflow on ticks.
      configure(32'd1000, 16'd60, 20'd44100, 16'd512);
      top = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(2000);
      run_session(100, top);

      // Extremes of the register ranges.
      configure(32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF, 16'hFFFF);
      run_session(90, rand64() >> 1);
      configure(32'hFFFF_FFFF, 16'd1, 20'd1, 16'hFFFF);
      run_session(40, rand64());
      configure(32'd1, 16'd1, 20'd1, 16'd1);
      run_session(90, rand64());

      // Reset values again, without any idling.
      calm = 1;
      configure(GuestReset, FrameReset, SampleReset, BufferReset);
      run_session(140, rand64() >> 2);
      calm = 0;

      // Random settings, mostly short cadences so both streams fire often.
      for (int p = 0; p < 8; p++) begin
         configure($urandom_range(50, 300000), 16'($urandom_range(1, 3000)),
                   20'($urandom_range(1, 20'hF_FFFF)), 16'($urandom_range(1, 16'hFFFF)));
         run_session(120, (p % 3 == 0) ? rand64() : {32'd0, $urandom});
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("[dual_fractional_media_tick_generator] OK");
      end else begin
         $display("[dual_fractional_media_tick_generator] ERROR");
      end
      $finish;
   end

endmodule
